// File: hdl/psr_pkg.sv
// ---------------------------------------------------------------------------
// psr_pkg
// Shared sizes and result codes of the per-source reorder buffer.
// ---------------------------------------------------------------------------
package psr_pkg;

  // Field widths of one transaction
  localparam int SRC_W    = 3;
  localparam int SEQ_W    = 32;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 2;

  // Number of sources and reorder window per source (window: power of two)
  localparam int NUM_SOURCES = 8;
  localparam int WINDOW      = 16;

  localparam int SRC_IDX_W = $clog2(NUM_SOURCES);
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int NUM_SLOTS = NUM_SOURCES * WINDOW;
  localparam int SLOT_IDX_W = SRC_IDX_W + SLOT_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

endpackage

// File: hdl/psr_ram.sv
// ---------------------------------------------------------------------------
// psr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module psr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/per_source_reorder_buffer.sv
// ---------------------------------------------------------------------------
// per_source_reorder_buffer
// Per-source sequence-number resequencer with a slot window per source.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries packets: source, 32-bit
//   sequence number and a payload word. Output channel (out_valid_o /
//   out_stall_i) carries results: delivered packets in sequence order
//   (status OK), or a single stale or beyond-window report that echoes the
//   input. last_o marks the final result caused by one input transaction;
//   a stored packet that does not close a gap causes no result at all.
//   The block works on one packet at a time and stalls input meanwhile:
//     - after accept, CHECK compares against the expected number; a report
//       is loaded into the output register there,
//     - a stored packet then goes to DRAIN to look at the expected slot,
//     - each released packet passes DRAIN, which issues the payload RAM read
//       and clears its valid bit, then READ, which takes the registered
//       read data. The payload RAM read sets the drain rate: the next slot
//       is read only after the previous one has gone into the output register.
//   Reset clears all expected numbers and slot valid bits at once; payload
//   memory needs no clearing since only valid slots are read.
//   A stalled receiver holds the output register; the sequencer waits
//   before loading the next result, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
module per_source_reorder_buffer import psr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transactions
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SRC_W-1:0]    source_i,
  input  logic [SEQ_W-1:0]    seq_num_i,
  input  logic [PAY_W-1:0]    payload_i,
  // output transactions
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SRC_W-1:0]    out_source_o,
  output logic [SEQ_W-1:0]    out_seq_num_o,
  output logic [PAY_W-1:0]    out_payload_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                last_o
);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // wait for a packet
  localparam logic [1:0] S_CHECK = 2'd1;  // classify, store or report
  localparam logic [1:0] S_DRAIN = 2'd2;  // probe the expected slot
  localparam logic [1:0] S_READ  = 2'd3;  // take RAM data into output

  logic [1:0] state_q, state_d;

  // Captured packet
  logic [SRC_W-1:0] src_q;
  logic [SEQ_W-1:0] seq_q;
  logic [PAY_W-1:0] pay_q;

  // Per-source expected sequence numbers and slot valid bits
  logic [SEQ_W-1:0]     exp_q [NUM_SOURCES];
  logic [NUM_SLOTS-1:0] valid_q;

  // Release bookkeeping
  logic [SEQ_W-1:0]      rel_seq_q;
  logic                  rel_last_q;
  logic [SLOT_IDX_W-1:0] rd_addr_q;

  // Output register
  logic                out_valid_q;
  logic [SRC_W-1:0]    out_src_q;
  logic [SEQ_W-1:0]    out_seq_q;
  logic [PAY_W-1:0]    out_pay_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  logic                  in_accept;
  logic                  src_ok;
  logic                  out_free;
  logic [SRC_IDX_W-1:0]  src_idx;
  logic [SEQ_W-1:0]      exp_cur;
  logic [SEQ_W-1:0]      fwd_dist;
  logic                  is_stale;
  logic                  is_over;
  logic [SLOT_W-1:0]     cur_slot;
  logic [SLOT_W-1:0]     nxt_slot;
  logic [SLOT_IDX_W-1:0] cur_idx;
  logic [SLOT_IDX_W-1:0] nxt_idx;
  logic [SLOT_IDX_W-1:0] st_idx;
  logic                  ram_we;
  logic                  ram_re;
  logic [PAY_W-1:0]      ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign src_ok     = (int'(source_i) < NUM_SOURCES);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign src_idx  = src_q[SRC_IDX_W-1:0];
  assign exp_cur  = exp_q[src_idx];
  // distance ahead of expected, modulo 2^32
  assign fwd_dist = seq_q - exp_cur;
  assign is_stale = fwd_dist[SEQ_W-1];
  assign is_over  = !is_stale && (fwd_dist >= SEQ_W'(WINDOW));

  assign cur_slot = exp_cur[SLOT_W-1:0];
  assign nxt_slot = cur_slot + 1'b1;
  assign cur_idx  = {src_idx, cur_slot};
  assign nxt_idx  = {src_idx, nxt_slot};
  assign st_idx   = {src_idx, seq_q[SLOT_W-1:0]};

  // Store in CHECK, read in DRAIN: the two never share a cycle, and a
  // write is complete before the slot can be probed.
  assign ram_we = (state_q == S_CHECK) && !is_stale && !is_over;
  assign ram_re = (state_q == S_DRAIN) && valid_q[cur_idx];

  psr_ram #(
    .WIDTH (PAY_W),
    .DEPTH (NUM_SLOTS)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (st_idx),
    .wdata_i (pay_q),
    .re_i    (ram_re),
    .raddr_i (cur_idx),
    .rdata_o (ram_rdata)
  );

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        // drop packets from sources outside the configured range
        if (in_accept && src_ok) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (is_stale || is_over) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = valid_q[cur_idx] ? S_READ : S_IDLE;
      end
      S_READ: begin
        if (out_free) state_d = rel_last_q ? S_IDLE : S_DRAIN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        exp_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[st_idx] <= 1'b1;
      end
      if (ram_re) begin
        // release the slot and advance the expected number
        valid_q[cur_idx] <= 1'b0;
        exp_q[src_idx]   <= exp_cur + 1'b1;
      end
      if ((state_q == S_CHECK && (is_stale || is_over) && out_free) ||
          (state_q == S_READ && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      src_q <= source_i;
      seq_q <= seq_num_i;
      pay_q <= payload_i;
    end
    if (ram_re) begin
      rel_seq_q  <= exp_cur;
      rd_addr_q  <= cur_idx;
      // the run ends where the following slot is empty
      rel_last_q <= !valid_q[nxt_idx];
    end
    if (state_q == S_CHECK && (is_stale || is_over) && out_free) begin
      out_src_q    <= src_q;
      out_seq_q    <= seq_q;
      out_pay_q    <= pay_q;
      out_status_q <= is_stale ? ST_STALE : ST_OVER;
      out_last_q   <= 1'b1;
    end else if (state_q == S_READ && out_free) begin
      out_src_q    <= src_q;
      out_seq_q    <= rel_seq_q;
      out_pay_q    <= ram_rdata;
      out_status_q <= ST_OK;
      out_last_q   <= rel_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_source_o  = out_src_q;
  assign out_seq_num_o = out_seq_q;
  assign out_payload_o = out_pay_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  // Reports always close their input's result list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> last_o)
    else $error("report without last flag");

  // A slot being delivered has already been released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !valid_q[rd_addr_q])
    else $error("delivered slot still marked valid");

  // An accepted in-range packet is classified in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && src_ok) |=> (state_q == S_CHECK))
    else $error("accepted packet not classified");

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_seq_num_o)))
    else $error("stalled result changed");
`endif

endmodule

// File: tb/sv/per_source_reorder_buffer_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_source_reorder_buffer_test
// Self-checking testbench of the per-source reorder buffer. Packets are sent
// through the valid/stall input channel, and a resequencing predictor models
// every accepted transaction. It keeps its own expected sequence numbers and
// window slots for each source. Each result is compared field by field with
// the oldest predicted release or report. Directed cases come first, then
// random traffic under four idling patterns on the two channels.
// ---------------------------------------------------------------------------
module per_source_reorder_buffer_test;
  import psr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;  // far above the slowest correct run
  localparam int TAIL_CYCLES = 40;      // wait for stray results after the drain
  localparam int PHASE_ITEMS = 120;

  // one predicted result: a release in order or a stale/overflow report
  typedef struct {
    logic [SRC_W-1:0]    source;
    logic [SEQ_W-1:0]    seq_num;
    logic [PAY_W-1:0]    payload;
    logic [STATUS_W-1:0] status;
    logic                last;
  } release_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [SRC_W-1:0]    source_i    = '0;
  logic [SEQ_W-1:0]    seq_num_i   = '0;
  logic [PAY_W-1:0]    payload_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SRC_W-1:0]    out_source_o;
  logic [SEQ_W-1:0]    out_seq_num_o;
  logic [PAY_W-1:0]    out_payload_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_o;

  // predictor state: next number to release per source, and window slots
  logic [SEQ_W-1:0] next_seq  [NUM_SOURCES];
  logic             slot_held [NUM_SLOTS];
  logic [PAY_W-1:0] slot_word [NUM_SLOTS];

  release_t release_queue[$];
  int       error_count   = 0;
  int       cycle_count   = 0;
  int       send_idle_pct = 0;
  int       stall_pct     = 0;

  per_source_reorder_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_i      (source_i),
    .seq_num_i     (seq_num_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_source_o  (out_source_o),
    .out_seq_num_o (out_seq_num_o),
    .out_payload_o (out_payload_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // End the run if the block hangs or the stimulus never drains.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** per_source_reorder_buffer: FAILED **");
    $finish;
  end

  // Receiver backpressure: redraw the stall every cycle at the phase's rate.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // -------------------------------------------------------------------------
  // Resequencing predictor. A stale or overflow packet is echoed as a single
  // report and leaves the state alone; an in-window packet is stored, then
  // every contiguous slot from the expected number is released in order.
  // The source field is exactly as wide as the source count, so no packet
  // is out of range.
  // -------------------------------------------------------------------------
  task automatic resequence_packet(input logic [SRC_W-1:0] src,
                                   input logic [SEQ_W-1:0] seq,
                                   input logic [PAY_W-1:0] pay);
    logic [SEQ_W-1:0] seq_dist;
    release_t         r;
    int               base;
    int               released;
    seq_dist = seq - next_seq[src];
    base     = int'(src) * WINDOW;
    released = 0;
    r.source = src;
    if (seq_dist[SEQ_W-1] || seq_dist >= WINDOW) begin
      // behind the expected number (upper half of the distance) or too far ahead
      r.seq_num = seq;
      r.payload = pay;
      r.status  = seq_dist[SEQ_W-1] ? ST_STALE : ST_OVER;
      r.last    = 1'b1;
      release_queue.insert(release_queue.size(), r);
    end else begin
      // store, overwriting a duplicate
      slot_held[base + int'(seq % WINDOW)] = 1'b1;
      slot_word[base + int'(seq % WINDOW)] = pay;
      while (released < WINDOW && slot_held[base + int'(next_seq[src] % WINDOW)]) begin
        r.seq_num = next_seq[src];
        r.payload = slot_word[base + int'(next_seq[src] % WINDOW)];
        r.status  = ST_OK;
        slot_held[base + int'(next_seq[src] % WINDOW)] = 1'b0;
        next_seq[src] = next_seq[src] + 1;
        released++;
        // last unless the next slot continues the run
        r.last = (released == WINDOW) ||
                 !slot_held[base + int'(next_seq[src] % WINDOW)];
        release_queue.insert(release_queue.size(), r);
      end
    end
  endtask

  // Send one packet: hold off for random idle cycles, then hold valid and
  // payload until the block takes the transaction.
  task automatic send_packet(input logic [SRC_W-1:0] src,
                             input logic [SEQ_W-1:0] seq,
                             input logic [PAY_W-1:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    source_i   <= src;
    seq_num_i  <= seq;
    payload_i  <= pay;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    resequence_packet(src, seq, pay);
  endtask

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_result
    release_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (release_queue.size() == 0) begin
        $display({"%0t ns: unexpected result, expected none, ",
                  "actual src %0d seq %h pay %h st %0d last %0b"},
                 $time, out_source_o, out_seq_num_o, out_payload_o, status_o, last_o);
        error_count++;
      end else begin
        want = release_queue.pop_front();
        check_field("source",  32'(want.source),  32'(out_source_o));
        check_field("seq_num", want.seq_num,      out_seq_num_o);
        check_field("payload", want.payload,      out_payload_o);
        check_field("status",  32'(want.status),  32'(status_o));
        check_field("last",    32'(want.last),    32'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests (no idling)
  // ---------------------------------------------------------------------------

  // Packets arriving in order release one by one; payload extremes.
  task automatic test_in_order_release();
    send_packet(3'd0, 32'd0, 32'h0000_0000);
    send_packet(3'd0, 32'd1, 32'hFFFF_FFFF);
  endtask

  // Fill the window backwards from its top slot down to slot 1 on the top source,
  // overwrite one slot, then close the gap at slot 0 so all sixteen release from one transaction.
  task automatic test_full_window_drain();
    for (int i = WINDOW - 1; i >= 1; i--)
      send_packet(3'd7, SEQ_W'(i), {16'hC0DE, 16'(i)});
    send_packet(3'd7, 32'd3, 32'hFFFF_FFFF);
    send_packet(3'd7, 32'd0, 32'h0000_0000);
  endtask

  // Source 0 now expects 2: probe both edges of the stale and overflow ranges,
  // and store at the far edge of the window without a release.
  task automatic test_stale_and_overflow();
    send_packet(3'd0, 32'd0,          32'h1111_1111);  // just released
    send_packet(3'd0, 32'hFFFF_FFFF,  32'h2222_2222);  // wraps just behind
    send_packet(3'd0, 32'h8000_0002,  32'h3333_3333);  // exactly half range away
    send_packet(3'd0, 32'd18,         32'h4444_4444);  // first beyond the window
    send_packet(3'd0, 32'h8000_0001,  32'h5555_5555);  // largest forward distance
    send_packet(3'd0, 32'd17,         32'h6666_6666);  // last slot of the window
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly shuffled runs starting at the expected number,
  // with stray in-window packets, stale and overflow noise mixed in.
  // ---------------------------------------------------------------------------
  task automatic random_traffic(input int n_items);
    int               sent;
    int               pick;
    int               burst_len;
    int               j;
    int               tmp;
    int               order[WINDOW];
    logic [SRC_W-1:0] src;
    logic [SEQ_W-1:0] base_seq;
    logic [SEQ_W-1:0] span;
    sent = 0;
    span = 32'h8000_0000 - WINDOW;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      src  = SRC_W'($urandom_range(NUM_SOURCES - 1));
      if (pick < 70) begin
        burst_len = $urandom_range(WINDOW, 1);
        base_seq  = next_seq[src];
        for (int i = 0; i < WINDOW; i++) order[i] = i;
        for (int i = burst_len - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        for (int i = 0; i < burst_len; i++) begin
          send_packet(src, base_seq + order[i], $urandom);
          sent++;
          // occasionally repeat a packet: overwrite, or stale once released
          if ($urandom_range(9) == 0) begin
            send_packet(src, base_seq + order[i], $urandom);
            sent++;
          end
        end
      end else if (pick < 80) begin
        send_packet(src, next_seq[src] + $urandom_range(WINDOW - 1), $urandom);
        sent++;
      end else if (pick < 88) begin
        send_packet(src, next_seq[src] - (($urandom & 32'h7FFF_FFFF) + 1), $urandom);
        sent++;
      end else if (pick < 95) begin
        send_packet(src, next_seq[src] + WINDOW + ($urandom % span), $urandom);
        sent++;
      end else begin
        send_packet(src, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  task automatic test_steady_traffic();
    send_idle_pct = 0;
    stall_pct     = 0;
    random_traffic(PHASE_ITEMS);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 78;
    stall_pct     = 0;
    random_traffic(PHASE_ITEMS);
  endtask

  task automatic test_receiver_backpressure();
    send_idle_pct = 0;
    stall_pct     = 78;
    random_traffic(PHASE_ITEMS);
  endtask

  task automatic test_mixed_idling();
    send_idle_pct = 20;
    stall_pct     = 20;
    random_traffic(PHASE_ITEMS);
  endtask

  initial begin
    for (int i = 0; i < NUM_SOURCES; i++) next_seq[i] = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_held[i] = 1'b0;
      slot_word[i] = '0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_in_order_release();
    test_full_window_drain();
    test_stale_and_overflow();
    test_steady_traffic();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_idling();

    // drop valid, let the last results drain, then allow for stray extras
    in_valid_i <= 1'b0;
    while (release_queue.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && release_queue.size() == 0) begin
      $display("** per_source_reorder_buffer: PASSED **");
    end else begin
      $display("** per_source_reorder_buffer: FAILED **");
    end
    $finish;
  end

endmodule
